// ===== rtl/ilfc_pkg.sv =====
package ilfc_pkg;

   // Field widths of the request and response words
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int SIDE_W     = 7;
   localparam int COST_W     = 13;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Request tdata layout, lowest bit first
   localparam int REQ_ROW_LSB  = 0;
   localparam int REQ_COL_LSB  = REQ_ROW_LSB + ROW_W;
   localparam int REQ_SPIN_BIT = REQ_COL_LSB + COL_W;

   // Response tdata layout, lowest bit first
   localparam int RSP_COST_LSB = 0;
   localparam int RSP_SPIN_BIT = RSP_COST_LSB + COST_W;

   localparam int MAX_SIDE_DEFAULT = 64;
   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

   // Item kinds carried on req_tuser
   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_FLIP = 1'b1;

   // Per-item controls handed to the cost update logic
   typedef struct packed {
      logic flip;
      logic spin_value;
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
   } ilfc_item_ctl_type;

endpackage

// ===== rtl/ilfc_row_bank.sv =====
module ilfc_row_bank #(
   parameter int WIDTH = ilfc_pkg::MAX_SIDE_DEFAULT,
   parameter int DEPTH = ilfc_pkg::MAX_SIDE_DEFAULT / 2,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/ilfc_cost_update.sv =====
module ilfc_cost_update #(
   parameter int MAX_SIDE = ilfc_pkg::MAX_SIDE_DEFAULT,
   parameter int CW       = $clog2(MAX_SIDE)
) (
   input  logic [MAX_SIDE-1:0]              own_word,
   input  logic                             up_spin,
   input  logic                             down_spin,
   input  logic [CW-1:0]                    col_idx,
   input  ilfc_pkg::ilfc_item_ctl_type      ctl,
   input  logic [ilfc_pkg::COST_W-1:0]      cost_cur,
   output logic [MAX_SIDE-1:0]              word_next,
   output logic                             spin_next,
   output logic                             changed,
   output logic [ilfc_pkg::COST_W-1:0]      cost_next
);

   logic          spin_old;
   logic          left_spin;
   logic          right_spin;
   logic [2:0]    exist_cnt;
   logic [2:0]    unlike_cnt;
   logic [CW-1:0] col_left;
   logic [CW-1:0] col_right;

   assign col_left  = col_idx - CW'(1);
   assign col_right = col_idx + CW'(1);
   assign spin_old   = own_word[col_idx];
   assign left_spin  = own_word[col_left];
   assign right_spin = own_word[col_right];

   assign changed   = ctl.flip || (ctl.spin_value != spin_old);
   assign spin_next = spin_old ^ changed;

   always_comb begin
      word_next          = own_word;
      word_next[col_idx] = ~spin_old;
   end

   // Each existing neighbor adds one if unlike the new spin, drops one otherwise
   always_comb begin
      exist_cnt  = 3'(ctl.has_up) + 3'(ctl.has_down) + 3'(ctl.has_left)
                 + 3'(ctl.has_right);
      unlike_cnt = 3'(ctl.has_up    && (up_spin    != spin_next))
                 + 3'(ctl.has_down  && (down_spin  != spin_next))
                 + 3'(ctl.has_left  && (left_spin  != spin_next))
                 + 3'(ctl.has_right && (right_spin != spin_next));
   end

   always_comb begin
      if (changed) begin
         cost_next = cost_cur + ilfc_pkg::COST_W'({unlike_cnt, 1'b0})
                   - ilfc_pkg::COST_W'(exist_cnt);
      end else begin
         cost_next = cost_cur;
      end
   end

endmodule

// ===== rtl/ising_lattice_flip_cost_update.sv =====
// Ising lattice flip-cost updater.
// Keeps a square lattice of one-bit spins (open boundaries) and a running count
// of unlike horizontal and vertical neighbor pairs.
// Request channel (req_*): one word per item; req_tuser is the kind (set or
// flip), req_tdata carries row, col and the spin to set.
// Response channel (rsp_*): one word per item with the cost after the item and
// the spin at the addressed cell; rsp_tuser flags coordinates outside the side
// in use (item ignored, cell spin reads 0).
// csr_wr_en / csr_wr_data write the side in use; write only while idle.
// A new item is accepted only after the last one is written back. On accept,
// three lattice rows (own, above, below) are read into the registered outputs
// of two row banks split by row parity; the update state then updates the cost
// and writes the own row back. The next read follows that write, so no
// forwarding is needed. The response word is registered at write-back.
// A stalled response holds in the output register; one more item is accepted
// and waits at its write-back until the output register frees.
// Reset: the cost clears, the side returns to 64 and a clearing pass writes
// zero rows to all ceil(MAX_SIDE/2) addresses of both banks (32 by default),
// during which req_tready stays low.
module ising_lattice_flip_cost_update #(
   parameter int MAX_SIDE = ilfc_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // row [5:0], col [11:6], spin_value [12], zero [15:13]
   input  logic [ilfc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind [0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // total_cost [12:0], cell_spin [13], zero [15:14]
   output logic [ilfc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // bad_index [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [ilfc_pkg::SIDE_W-1:0]         csr_wr_data
);

   localparam int CW         = $clog2(MAX_SIDE);
   localparam int BANK_DEPTH = (MAX_SIDE + 1) / 2;
   localparam int BW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int SW_RAW     = $clog2(MAX_SIDE + 1);
   localparam int SW         = (SW_RAW > ilfc_pkg::SIDE_W) ? SW_RAW : ilfc_pkg::SIDE_W;
   localparam int ROW_W      = ilfc_pkg::ROW_W;
   localparam int COL_W      = ilfc_pkg::COL_W;
   localparam int COST_W     = ilfc_pkg::COST_W;

   typedef enum logic [2:0] {
      S_CLEAR  = 3'b001,
      S_IDLE   = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration and running cost
   logic [ilfc_pkg::SIDE_W-1:0] side_ff;
   logic [SW-1:0]               side_eff;
   logic [COST_W-1:0]           cost_ff, cost_in;

   // Clearing pass
   logic [BW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          clearing;

   // Accepted item
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic             kind_ff;
   logic             spin_value_ff;
   logic             bad_ff;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0] rsp_cost_ff;
   logic              rsp_spin_ff;
   logic              rsp_bad_ff;

   // Request decode
   logic [ROW_W-1:0] req_row;
   logic [COL_W-1:0] req_col;
   logic             req_fire;
   logic             req_bad;
   logic [ROW_W-1:0] row_up_w;
   logic [ROW_W:0]   row_dn_w;
   logic [BW-1:0]    addr_own;
   logic [BW-1:0]    addr_up;
   logic [BW-1:0]    addr_dn;

   // Bank ports
   logic [BW-1:0]       b0_rd_addr_a, b1_rd_addr_a;
   logic [MAX_SIDE-1:0] b0_rd_data_a, b0_rd_data_b;
   logic [MAX_SIDE-1:0] b1_rd_data_a, b1_rd_data_b;
   logic                b0_wr_en, b1_wr_en;
   logic [BW-1:0]       wr_addr;
   logic [MAX_SIDE-1:0] wr_data;

   // Update stage
   logic [MAX_SIDE-1:0]         own_word;
   logic [MAX_SIDE-1:0]         up_word;
   logic [MAX_SIDE-1:0]         down_word;
   logic [CW-1:0]               col_idx;
   ilfc_pkg::ilfc_item_ctl_type item_ctl;
   logic [MAX_SIDE-1:0]         word_next;
   logic                        spin_next;
   logic                        changed;
   logic [COST_W-1:0]           cost_next;
   logic                        out_free;
   logic                        upd_fire;
   logic                        upd_write;

   // ---------------------------------------------------------------------
   // Side in use, saturated to 1..MAX_SIDE
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= ilfc_pkg::SIDE_RESET;
      end else if (csr_wr_en) begin
         side_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (side_ff == '0) begin
         side_eff = SW'(1);
      end else if (SW'(side_ff) > SW'(MAX_SIDE)) begin
         side_eff = SW'(MAX_SIDE);
      end else begin
         side_eff = SW'(side_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Request side: accept and issue the three row reads
   // ---------------------------------------------------------------------
   assign clearing   = (state_ff == S_CLEAR);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign req_row = req_tdata[ilfc_pkg::REQ_ROW_LSB +: ROW_W];
   assign req_col = req_tdata[ilfc_pkg::REQ_COL_LSB +: COL_W];
   assign req_bad = (SW'(req_row) >= side_eff) || (SW'(req_col) >= side_eff);

   // Rows above and below share a parity; the own row sits in the other bank
   assign row_up_w = req_row - ROW_W'(1);
   assign row_dn_w = {1'b0, req_row} + (ROW_W + 1)'(1);
   assign addr_own = BW'(req_row >> 1);
   assign addr_up  = BW'(row_up_w >> 1);
   assign addr_dn  = BW'(row_dn_w >> 1);

   assign b0_rd_addr_a = req_row[0] ? addr_up : addr_own;
   assign b1_rd_addr_a = req_row[0] ? addr_own : addr_up;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         row_ff        <= req_row;
         col_ff        <= req_col;
         kind_ff       <= req_tuser;
         spin_value_ff <= req_tdata[ilfc_pkg::REQ_SPIN_BIT];
         bad_ff        <= req_bad;
      end
   end

   // ---------------------------------------------------------------------
   // Row banks: even rows and odd rows
   // ---------------------------------------------------------------------
   ilfc_row_bank #(
      .WIDTH (MAX_SIDE),
      .DEPTH (BANK_DEPTH),
      .AW    (BW)
   ) u_bank_even (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_addr_a (b0_rd_addr_a),
      .rd_addr_b (addr_dn),
      .rd_data_a (b0_rd_data_a),
      .rd_data_b (b0_rd_data_b),
      .wr_en     (b0_wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   ilfc_row_bank #(
      .WIDTH (MAX_SIDE),
      .DEPTH (BANK_DEPTH),
      .AW    (BW)
   ) u_bank_odd (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_addr_a (b1_rd_addr_a),
      .rd_addr_b (addr_dn),
      .rd_data_a (b1_rd_data_a),
      .rd_data_b (b1_rd_data_b),
      .wr_en     (b1_wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // ---------------------------------------------------------------------
   // Update stage: pick rows by parity, compute the new cost
   // ---------------------------------------------------------------------
   assign own_word  = row_ff[0] ? b1_rd_data_a : b0_rd_data_a;
   assign up_word   = row_ff[0] ? b0_rd_data_a : b1_rd_data_a;
   assign down_word = row_ff[0] ? b0_rd_data_b : b1_rd_data_b;
   assign col_idx   = CW'(col_ff);

   assign item_ctl.flip       = (kind_ff == ilfc_pkg::KIND_FLIP);
   assign item_ctl.spin_value = spin_value_ff;
   assign item_ctl.has_up     = (row_ff != '0);
   assign item_ctl.has_left   = (col_ff != '0);
   assign item_ctl.has_down   = ((SW'(row_ff) + SW'(1)) < side_eff);
   assign item_ctl.has_right  = ((SW'(col_ff) + SW'(1)) < side_eff);

   ilfc_cost_update #(
      .MAX_SIDE (MAX_SIDE),
      .CW       (CW)
   ) u_cost_update (
      .own_word  (own_word),
      .up_spin   (up_word[col_idx]),
      .down_spin (down_word[col_idx]),
      .col_idx   (col_idx),
      .ctl       (item_ctl),
      .cost_cur  (cost_ff),
      .word_next (word_next),
      .spin_next (spin_next),
      .changed   (changed),
      .cost_next (cost_next)
   );

   // Hold the write-back until the output register can take the result
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign upd_fire  = (state_ff == S_UPDATE) && out_free;
   assign upd_write = upd_fire && !bad_ff && changed;

   assign wr_addr  = clearing ? clr_cnt_ff : BW'(row_ff >> 1);
   assign wr_data  = clearing ? '0 : word_next;
   assign b0_wr_en = clearing || (upd_write && !row_ff[0]);
   assign b1_wr_en = clearing || (upd_write && row_ff[0]);

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + BW'(1);
            if (clr_cnt_ff == BW'(BANK_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign cost_in      = upd_write ? cost_next : cost_ff;
   assign rsp_valid_in = upd_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response word at write-back
   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_cost_ff <= cost_in;
         rsp_spin_ff <= !bad_ff && spin_next;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_bad_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[ilfc_pkg::RSP_COST_LSB +: COST_W] = rsp_cost_ff;
      rsp_tdata[ilfc_pkg::RSP_SPIN_BIT]           = rsp_spin_ff;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_then_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_UPDATE))
      else $error("accepted word did not move to update");

   a_bad_spin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tdata[ilfc_pkg::RSP_SPIN_BIT])
      else $error("out-of-range response carries a nonzero spin");

   a_bad_keeps_cost: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && bad_ff) |=> $stable(cost_ff))
      else $error("out-of-range item changed the cost");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(b0_wr_en || b1_wr_en))
      else $error("row bank written while idle");

endmodule
